// ===== hdl/base64_line_wrapped_encoder_top_assert.svh =====
// assertion macros for the line-wrapped base64 encoder top level
`ifndef BASE64_LINE_WRAPPED_ENCODER_TOP_ASSERT_SVH
`define BASE64_LINE_WRAPPED_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define B64LWE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("b64lwe same-cycle check failed");

// next-cycle implication, checked out of reset
`define B64LWE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("b64lwe next-cycle check failed");

`endif

// ===== hdl/b64lwe_pkg.sv =====
// shared types, constants and the alphabet lookup for the base64 encoder
`timescale 1ns / 1ps
`default_nettype none
package b64lwe_pkg;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] LINE_WIDTH_RST = 8'd76;

    // up to four characters, data and padding, caused by one byte
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            last;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    function automatic logic [7:0] f_b64_char(input logic [5:0] idx);
        logic [7:0] v;
        v = {2'b00, idx};
        if (idx < 6'd26) begin
            f_b64_char = 8'h41 + v;
        end else if (idx < 6'd52) begin
            f_b64_char = 8'h61 + v - 8'd26;
        end else if (idx < 6'd62) begin
            f_b64_char = 8'h30 + v - 8'd52;
        end else if (idx == 6'd62) begin
            f_b64_char = 8'h2B;
        end else begin
            f_b64_char = 8'h2F;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/b64lwe_front.sv =====
// front end: group phase tracking and data character generation per byte
`timescale 1ns / 1ps
`default_nettype none
module b64lwe_front
    import b64lwe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output t_entry          o_entry
);

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_ONE   = 2'd1;
    localparam logic [1:0] PH_TWO   = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_carry, n_carry;

    always_comb begin
        o_entry.chars    = {4{CHAR_PAD}};
        o_entry.last_idx = 2'd0;
        o_entry.last     = i_last_byte;
        n_phase          = r_phase;
        n_carry          = r_carry;
        unique case (r_phase)
            PH_ONE: begin
                o_entry.chars[0] = f_b64_char({r_carry[1:0], i_data_byte[7:4]});
                o_entry.chars[1] = f_b64_char({i_data_byte[3:0], 2'b00});
                o_entry.last_idx = i_last_byte ? 2'd2 : 2'd0;
                n_phase          = PH_TWO;
                n_carry          = i_data_byte[3:0];
            end
            PH_TWO: begin
                o_entry.chars[0] = f_b64_char({r_carry, i_data_byte[7:6]});
                o_entry.chars[1] = f_b64_char(i_data_byte[5:0]);
                o_entry.last_idx = 2'd1;
                n_phase          = PH_START;
                n_carry          = 4'd0;
            end
            default: begin
                // unused phase code behaves as the start of a group
                o_entry.chars[0] = f_b64_char(i_data_byte[7:2]);
                o_entry.chars[1] = f_b64_char({i_data_byte[1:0], 4'b0000});
                o_entry.last_idx = i_last_byte ? 2'd3 : 2'd0;
                n_phase          = PH_ONE;
                n_carry          = {2'b00, i_data_byte[1:0]};
            end
        endcase
        if (i_last_byte) begin
            n_phase = PH_START;
            n_carry = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_carry <= 4'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/b64lwe_fifo.sv =====
// short first-word-fall-through queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
module b64lwe_fifo
    import b64lwe_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_wr,
    input  wire t_entry i_wr_data,
    input  wire logic   i_rd,
    output t_entry      o_rd_data,
    output t_q_stat     o_stat
);

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == Q_DEPTH[Q_AW:0]);
    assign o_rd_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/b64lwe_back.sv =====
// back end: column and CR LF insertion, one char per cycle unless held
`timescale 1ns / 1ps
`default_nettype none
module b64lwe_back
    import b64lwe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_line_width,
    input  wire t_entry     i_head,
    input  wire t_q_stat    i_q_stat,
    output logic            o_q_pop,
    input  wire logic       i_pop,
    output logic            o_empty,
    output logic [7:0]      o_out_char,
    output logic            o_run_end,
    output logic            o_message_end
);

    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_CR   = 2'd1;
    localparam logic [1:0] ST_LF   = 2'd2;

    logic [1:0] r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic [7:0] r_col, n_col;
    logic       r_done, n_done;
    logic       r_out_valid;
    logic [7:0] r_out_char, n_out_char;
    logic       r_run_end, n_run_end;
    logic       r_msg_end;

    logic       step;
    logic [7:0] eff_w;
    logic       wrap_on;
    logic [7:0] col_inc;
    logic       is_last_ch;
    logic       brk;
    logic       crlf;

    // a width of one behaves as two; a width of zero turns wrapping off
    assign eff_w   = (i_line_width == 8'd1) ? 8'd2 : i_line_width;
    assign wrap_on = (eff_w != 8'd0);
    assign step    = !i_q_stat.empty && (!r_out_valid || i_pop);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_col      = r_col;
        n_done     = r_done;
        n_out_char = i_head.chars[r_idx];
        n_run_end  = 1'b0;
        o_q_pop    = 1'b0;
        is_last_ch = (r_idx == i_head.last_idx);
        col_inc    = wrap_on ? r_col + 8'd1 : r_col;
        brk        = wrap_on && (col_inc >= eff_w);
        // a message always closes its line when wrapping is on
        crlf       = brk || (is_last_ch && i_head.last && wrap_on && col_inc != 8'd0);
        unique case (r_state)
            ST_CR: begin
                n_out_char = CHAR_CR;
                n_state    = ST_LF;
            end
            ST_LF: begin
                n_out_char = CHAR_LF;
                n_run_end  = r_done;
                n_col      = 8'd0;
                n_state    = ST_DATA;
                if (r_done) begin
                    o_q_pop = step;
                    n_idx   = 2'd0;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            default: begin
                n_run_end = is_last_ch && !crlf;
                if (crlf) begin
                    n_state = ST_CR;
                    n_done  = is_last_ch;
                    n_col   = brk ? 8'd0 : col_inc;
                end else if (is_last_ch) begin
                    o_q_pop = step;
                    n_idx   = 2'd0;
                    n_col   = i_head.last ? 8'd0 : col_inc;
                end else begin
                    n_idx = r_idx + 2'd1;
                    n_col = col_inc;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_DATA;
            r_idx       <= 2'd0;
            r_col       <= 8'd0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_state     <= n_state;
                r_idx       <= n_idx;
                r_col       <= n_col;
                r_done      <= n_done;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_char <= n_out_char;
            r_run_end  <= n_run_end;
            r_msg_end  <= n_run_end && i_head.last;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_out_char    = r_out_char;
    assign o_run_end     = r_run_end;
    assign o_message_end = r_msg_end;

endmodule
`default_nettype wire

// ===== hdl/base64_line_wrapped_encoder_top.sv =====
// Path: a taken byte is written to the queue, and its first character is then registered at the back end output.
// Input: one byte a cycle while the two-entry queue has room.
// Output: the back end gives one character a cycle while the queue holds an entry and its output is
// free or popped, one for each character a byte causes, line ends included.
// Reset (synchronous, active low) clears group phase, column and queue; width goes to 76.
`timescale 1ns / 1ps
`default_nettype none
`include "base64_line_wrapped_encoder_top_assert.svh"
module base64_line_wrapped_encoder_top
    import b64lwe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_char,
    output logic            o_run_end,
    output logic            o_message_end
);

    logic [7:0] r_line_width;
    logic       accept;
    t_entry     front_entry;
    t_entry     q_head;
    t_q_stat    q_stat;
    logic       q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
        end else if (i_cfg_wr_en) begin
            r_line_width <= i_cfg_wr_data;
        end
    end

    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;

    b64lwe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_entry     (front_entry)
    );

    b64lwe_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (accept),
        .i_wr_data (front_entry),
        .i_rd      (q_pop),
        .o_rd_data (q_head),
        .o_stat    (q_stat)
    );

    b64lwe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line_width  (r_line_width),
        .i_head        (q_head),
        .i_q_stat      (q_stat),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_char    (o_out_char),
        .o_run_end     (o_run_end),
        .o_message_end (o_message_end)
    );

    // end of message is always the end of that byte's run
    `B64LWE_ASSERT_SAME(a_msg_end_run_end, !empty && o_message_end, o_run_end)
    // a wrapped message always finishes on a line feed
    `B64LWE_ASSERT_SAME(a_wrapped_ends_lf, !empty && o_message_end && r_line_width != 8'd0,
        o_out_char == CHAR_LF)
    // a carriage return taken is followed straight away by its line feed
    `B64LWE_ASSERT_NEXT(a_cr_then_lf, !empty && pop && o_out_char == CHAR_CR,
        !empty && o_out_char == CHAR_LF)

endmodule
`default_nettype wire
